// ----- rtl/fbc_pkg.sv -----
// Shared types, constants and CRC byte-update functions for the frame builder.
// No dependencies; used by every module of the block.
package fbc_pkg;

	localparam logic [10:0] MAX_PAYLOAD  = 11'd1024;
	localparam logic [7:0]  START_RESET  = 8'hA5;
	localparam logic [7:0]  CRC8_INIT    = 8'hFF;
	localparam logic [7:0]  CRC8_POLY    = 8'h31;
	localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY   = 16'hA001;
	localparam int          IN_DATA_W    = 48;

	typedef enum logic [3:0] {
		PH_START,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_SEQ,
		PH_CRC8,
		PH_CMD_LO,
		PH_CMD_HI,
		PH_PAYLOAD,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	typedef struct packed {
		logic [10:0] payload_length;
		logic [7:0]  sequence_number;
		logic [15:0] command_id;
		logic [7:0]  payload_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       run_last;
		logic       frame_last;
	} result_t;

	// CRC8, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC8_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// reflected CRC16, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = {1'b0, c[15:1]} ^ CRC16_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/fbc_in_reg.sv -----
// Input register stage of the frame builder: holds one item until the engine
// has emitted all of its bytes. Depends on fbc_pkg.
module fbc_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fbc_pkg::item_t in_item,
	input  logic          pop,
	output logic          valid_s1,
	output fbc_pkg::item_t item_s1
);

	// take a new item in the same cycle the held one finishes
	assign in_ready = !valid_s1 || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/fbc_engine.sv -----
// Byte sequencer of the frame builder: walks header, payload and trailer phases,
// keeps CRC8/CRC16 and the payload count, and drives the result register.
// Depends on fbc_pkg.
module fbc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  fbc_pkg::item_t  item_s1,
	input  logic [7:0]      start_byte,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output fbc_pkg::result_t out_res
);

	fbc_pkg::phase_t phase_q;
	fbc_pkg::phase_t cur_phase;
	fbc_pkg::phase_t next_phase;
	logic            fresh_q;
	logic [10:0]     rem_q;
	logic [7:0]      crc8_q;
	logic [15:0]     crc16_q;
	logic            out_valid_q;
	fbc_pkg::result_t res_q;

	logic            adv;
	logic            done;
	logic [10:0]     len_sat;
	logic [10:0]     flen;
	logic [7:0]      byte_d;

	assign len_sat = (item_s1.payload_length > fbc_pkg::MAX_PAYLOAD) ?
		fbc_pkg::MAX_PAYLOAD : item_s1.payload_length;
	assign flen    = len_sat + 11'd2;

	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign pop = adv && done;

	// first byte of an item: new frame when idle, else a payload byte
	assign cur_phase = fresh_q ?
		((rem_q == 11'd0) ? fbc_pkg::PH_START : fbc_pkg::PH_PAYLOAD) : phase_q;

	// next state
	always_comb begin
		next_phase = cur_phase;
		done       = 1'b0;
		unique case (cur_phase)
			fbc_pkg::PH_START:   next_phase = fbc_pkg::PH_LEN_LO;
			fbc_pkg::PH_LEN_LO:  next_phase = fbc_pkg::PH_LEN_HI;
			fbc_pkg::PH_LEN_HI:  next_phase = fbc_pkg::PH_SEQ;
			fbc_pkg::PH_SEQ:     next_phase = fbc_pkg::PH_CRC8;
			fbc_pkg::PH_CRC8:    next_phase = fbc_pkg::PH_CMD_LO;
			fbc_pkg::PH_CMD_LO:  next_phase = fbc_pkg::PH_CMD_HI;
			fbc_pkg::PH_CMD_HI: begin
				next_phase = (rem_q == 11'd0) ? fbc_pkg::PH_CRC_LO : fbc_pkg::PH_PAYLOAD;
			end
			fbc_pkg::PH_PAYLOAD: begin
				next_phase = fbc_pkg::PH_CRC_LO;
				done       = (rem_q != 11'd1);
			end
			fbc_pkg::PH_CRC_LO:  next_phase = fbc_pkg::PH_CRC_HI;
			fbc_pkg::PH_CRC_HI: begin
				next_phase = fbc_pkg::PH_START;
				done       = 1'b1;
			end
			default:             next_phase = fbc_pkg::PH_START;
		endcase
	end

	// outputs
	always_comb begin
		unique case (cur_phase)
			fbc_pkg::PH_START:   byte_d = start_byte;
			fbc_pkg::PH_LEN_LO:  byte_d = flen[7:0];
			fbc_pkg::PH_LEN_HI:  byte_d = {5'b00000, flen[10:8]};
			fbc_pkg::PH_SEQ:     byte_d = item_s1.sequence_number;
			fbc_pkg::PH_CRC8:    byte_d = crc8_q;
			fbc_pkg::PH_CMD_LO:  byte_d = item_s1.command_id[7:0];
			fbc_pkg::PH_CMD_HI:  byte_d = item_s1.command_id[15:8];
			fbc_pkg::PH_PAYLOAD: byte_d = item_s1.payload_byte;
			fbc_pkg::PH_CRC_LO:  byte_d = crc16_q[7:0];
			fbc_pkg::PH_CRC_HI:  byte_d = crc16_q[15:8];
			default:             byte_d = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fbc_pkg::PH_START;
			fresh_q <= 1'b1;
			rem_q   <= 11'd0;
			crc8_q  <= fbc_pkg::CRC8_INIT;
			crc16_q <= fbc_pkg::CRC16_INIT;
		end else if (adv) begin
			phase_q <= next_phase;
			fresh_q <= done;
			unique case (cur_phase)
				fbc_pkg::PH_START: begin
					rem_q   <= len_sat;
					crc16_q <= fbc_pkg::crc16_byte(fbc_pkg::CRC16_INIT, byte_d);
				end
				fbc_pkg::PH_LEN_LO: begin
					crc8_q  <= fbc_pkg::crc8_byte(fbc_pkg::CRC8_INIT, byte_d);
					crc16_q <= fbc_pkg::crc16_byte(crc16_q, byte_d);
				end
				fbc_pkg::PH_LEN_HI, fbc_pkg::PH_SEQ: begin
					crc8_q  <= fbc_pkg::crc8_byte(crc8_q, byte_d);
					crc16_q <= fbc_pkg::crc16_byte(crc16_q, byte_d);
				end
				fbc_pkg::PH_PAYLOAD: begin
					rem_q   <= rem_q - 11'd1;
					crc16_q <= fbc_pkg::crc16_byte(crc16_q, byte_d);
				end
				fbc_pkg::PH_CRC_LO: begin
					crc16_q <= crc16_q;
				end
				fbc_pkg::PH_CRC_HI: begin
					crc16_q <= fbc_pkg::CRC16_INIT;
				end
				default: begin
					crc16_q <= fbc_pkg::crc16_byte(crc16_q, byte_d);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.frame_byte <= byte_d;
			res_q.run_last   <= done;
			res_q.frame_last <= (cur_phase == fbc_pkg::PH_CRC_HI);
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	a_flast_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_last |-> res_q.run_last)
		else $error("frame end not marked as end of item");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid_s1)
		else $error("item released while none held");

	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cur_phase == fbc_pkg::PH_CRC_HI |=> crc16_q == fbc_pkg::CRC16_INIT && rem_q == 11'd0)
		else $error("CRC16 or count not cleared after frame end");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= fbc_pkg::MAX_PAYLOAD)
		else $error("payload count above maximum");

endmodule

// ----- rtl/frame_builder_crc8_crc16_core.sv -----
// An item's first byte passes the input register, then the result register, to m_axis.
// Throughput: the sequencer writes one byte per cycle to the result register unless m_axis
// stalls; a frame-start item gives seven header bytes, its payload byte if the length is
// nonzero, the CRC16 trailer if it ends the frame; a payload item one byte, then the trailer if last.
// Reset: arst_n clears to idle, CRC16 0xFFFF, start_byte 0xA5.
module frame_builder_crc8_crc16_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] payload_byte, [23:8] command_id, [31:24] sequence_number,
	// [42:32] payload_length, [47:43] zero
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] frame_byte
	output logic [7:0]  m_axis_tdata,
	// [0] run_last
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0]       start_byte_q;
	fbc_pkg::item_t   in_item;
	fbc_pkg::item_t   item_s1;
	fbc_pkg::result_t res;
	logic             valid_s1;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= fbc_pkg::START_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_byte_q <= cfg_data;
		end
	end

	assign in_item.payload_byte    = s_axis_tdata[7:0];
	assign in_item.command_id      = s_axis_tdata[23:8];
	assign in_item.sequence_number = s_axis_tdata[31:24];
	assign in_item.payload_length  = s_axis_tdata[42:32];

	fbc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.pop      (pop),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fbc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.start_byte (start_byte_q),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = res.frame_byte;
	assign m_axis_tuser = res.run_last;
	assign m_axis_tlast = res.frame_last;

endmodule
